// ----- rtl/core/ncdf_pkg.sv -----
// Shared constants, stage counts and the side-band item record for the
// normal CDF pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncdf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS_DEF  = 16;

  // Internal Q30 format; QW bits hold 0 .. 1.0
  localparam int QB = 30;
  localparam int QW = QB + 1;
  localparam logic [QW-1:0] QONE = 31'h4000_0000;

  localparam int ZW = 33;  // z below 6.0 in Q30
  localparam int KW = 7;   // integer part of the exponent

  localparam logic [28:0] COEF_P  = 29'd351748265;
  localparam logic [29:0] Q_LN2   = 30'd744261118;
  localparam logic [30:0] Q_LOG2E = 31'd1549082005;

  localparam int HAW = 35;
  localparam logic signed [HAW-1:0] HRN_A5 = 35'sd1139675401;
  localparam logic signed [HAW-1:0] HRN_ADD [5] = '{
    -35'sd1560310108, 35'sd1526231383, -35'sd305476044, 35'sd273621191, 35'sd0
  };

  localparam int EXP_TERMS = 12;

  localparam int DIST_NS = 3;
  localparam int EXP_NS  = 3 + 3 * EXP_TERMS + 1;
  localparam int DIV_NS  = 2 + QW;
  localparam int HRN_NS  = 10;
  localparam int OUT_NS  = 2;

  localparam int EXP_OFS = DIST_NS;
  localparam int DIV_OFS = EXP_OFS + EXP_NS;
  localparam int HRN_OFS = DIV_OFS + DIV_NS;
  localparam int OUT_OFS = HRN_OFS + HRN_NS;
  localparam int NUM_STAGES = OUT_OFS + OUT_NS;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN      = 1'b0,
    REG_INV_SCALE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic          below;
    logic          sat;
    logic [ZW-1:0] z;
    logic [KW-1:0] k;
    logic [QW-1:0] e;
    logic [QW-1:0] t;
    logic [QW-1:0] pt;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/ncdf_dist.sv -----
// Distance stage: |x - mean| * inverse_scale, saturation flag and z in Q30.
// Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_dist #(
  parameter int FRAC_BITS = ncdf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [ncdf_pkg::DIST_NS-1:0]  en_i,
  input  logic signed [31:0]            sample_i,
  input  logic signed [31:0]            mean_i,
  input  logic [31:0]                   inverse_scale_i,
  output ncdf_pkg::side_t               side_o
);
  import ncdf_pkg::*;

  localparam int PW = 64;
  localparam int ZR = (2 * FRAC_BITS >= QB) ? 2 * FRAC_BITS - QB : 0;
  localparam int ZL = (2 * FRAC_BITS >= QB) ? 0 : QB - 2 * FRAC_BITS;
  localparam logic [PW-1:0] CUT = 64'(6) << (2 * FRAC_BITS);

  logic signed [32:0] diff;
  logic [32:0]        d_q;
  logic               below_q, below1_q;
  logic [48:0]        pp_lo_q, pp_hi_q;
  logic [PW-1:0]      prod, zfull;
  side_t              side_d, side_q;

  assign diff = 33'(sample_i) - 33'(mean_i);

  always_comb begin
    prod  = PW'(pp_lo_q) + (PW'(pp_hi_q) << 16);
    zfull = (2 * FRAC_BITS >= QB) ? (prod >> ZR) : (prod << ZL);
    side_d       = '0;
    side_d.below = below1_q;
    side_d.sat   = (prod >= CUT);
    side_d.z     = zfull[ZW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      below_q <= diff[32];
      d_q     <= diff[32] ? 33'(-diff) : 33'(diff);
    end
    if (en_i[1]) begin
      below1_q <= below_q;
      pp_lo_q  <= d_q * inverse_scale_i[15:0];
      pp_hi_q  <= d_q * inverse_scale_i[31:16];
    end
    if (en_i[2]) begin
      side_q <= side_d;
    end
  end

  assign side_o = side_q;

endmodule

`default_nettype wire

// ----- rtl/core/ncdf_exp.sv -----
// exp(-z^2) as 2^-(k+f): square, log2(e) scale, 12-term series with
// reciprocal-multiply division, final shift. Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_exp (
  input  logic                         clk_i,
  input  logic [ncdf_pkg::EXP_NS-1:0]  en_i,
  input  ncdf_pkg::side_t              side_i,
  output ncdf_pkg::side_t              side_o
);
  import ncdf_pkg::*;

  localparam int LAST = EXP_NS - 1;

  side_t         sd_d [EXP_NS];
  side_t         sd_q [EXP_NS];
  logic [61:0]   sq_q;
  logic [62:0]   up_q;
  logic [59:0]   gp_q;
  logic [36:0]   u;
  logic [QW-1:0] s_q  [EXP_TERMS];
  logic [29:0]   gc_q [EXP_TERMS];

  assign u = up_q[62:26];

  always_comb begin
    for (int j = 0; j < EXP_NS; j++) begin
      sd_d[j] = (j == 0) ? side_i : sd_q[j-1];
    end
    sd_d[2].k = u[36:30];
    sd_d[LAST].e = (sd_q[LAST-1].k >= KW'(QW)) ? '0 : (s_q[EXP_TERMS-1] >> sd_q[LAST-1].k);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < EXP_NS; j++) begin
      if (en_i[j]) sd_q[j] <= sd_d[j];
    end
    if (en_i[0]) sq_q <= side_i.z[ZW-1:2] * side_i.z[ZW-1:2];
    if (en_i[1]) up_q <= sq_q[61:30] * Q_LOG2E;
    if (en_i[2]) gp_q <= u[29:0] * Q_LN2;
  end

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
    localparam int SA = 3 + 3 * i;
    localparam logic [3:0]  N_L   = 4'(EXP_TERMS - i);
    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / (EXP_TERMS - i));

    logic [29:0]   g_in;
    logic [QW-1:0] s_in;
    logic [60:0]   m_q;
    logic [29:0]   ga_q, gb_q, vb_q;
    logic [62:0]   qp_q;
    logic [29:0]   q0, qn, r, q;

    assign g_in = (i == 0) ? gp_q[59:30] : gc_q[(i == 0) ? 0 : i-1];
    assign s_in = (i == 0) ? QONE : s_q[(i == 0) ? 0 : i-1];
    assign q0   = qp_q[61:32];
    assign qn   = q0 * N_L;
    assign r    = vb_q - qn;
    assign q    = q0 + 30'(r >= 30'(N_L));

    always_ff @(posedge clk_i) begin
      if (en_i[SA]) begin
        m_q  <= g_in * s_in;
        ga_q <= g_in;
      end
      if (en_i[SA+1]) begin
        qp_q <= m_q[59:30] * RECIP;
        vb_q <= m_q[59:30];
        gb_q <= ga_q;
      end
      if (en_i[SA+2]) begin
        s_q[i]  <= QONE - {1'b0, q};
        gc_q[i] <= gb_q;
      end
    end
  end

  assign side_o = sd_q[LAST];

endmodule

`default_nettype wire

// ----- rtl/core/ncdf_div.sv -----
// t = 2^60 / (2^30 + p*z): p*z product, then one restoring quotient bit
// per stage. Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_div (
  input  logic                         clk_i,
  input  logic [ncdf_pkg::DIV_NS-1:0]  en_i,
  input  ncdf_pkg::side_t              side_i,
  output ncdf_pkg::side_t              side_o
);
  import ncdf_pkg::*;

  localparam int LAST = DIV_NS - 1;

  side_t         sd_d [DIV_NS];
  side_t         sd_q [DIV_NS];
  logic [61:0]   pz_q;
  logic [31:0]   den_q;
  logic [31:0]   rem_q [QW];
  logic [31:0]   dn_q  [QW];
  logic [QW-1:0] quo_q [QW];

  always_comb begin
    for (int j = 0; j < DIV_NS; j++) begin
      sd_d[j] = (j == 0) ? side_i : sd_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_NS; j++) begin
      if (en_i[j]) sd_q[j] <= sd_d[j];
    end
    if (en_i[0]) pz_q  <= side_i.z * COEF_P;
    if (en_i[1]) den_q <= 32'(QONE) + pz_q[61:30];
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    logic [31:0]   r_in, d_in;
    logic [QW-1:0] q_in;
    logic [32:0]   r2, diff;
    logic          take;

    assign r_in = (i == 0) ? 32'h2000_0000 : rem_q[(i == 0) ? 0 : i-1];
    assign d_in = (i == 0) ? den_q : dn_q[(i == 0) ? 0 : i-1];
    assign q_in = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i-1];
    assign r2   = {r_in, 1'b0};
    assign diff = r2 - {1'b0, d_in};
    assign take = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i[2+i]) begin
        rem_q[i] <= take ? diff[31:0] : r2[31:0];
        dn_q[i]  <= d_in;
        quo_q[i] <= {q_in[QW-2:0], take};
      end
    end
  end

  // last quotient bit lands in the same stage as the last side register
  always_comb begin
    side_o   = sd_q[LAST];
    side_o.t = quo_q[QW-1];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ncdf_hrn.sv -----
// Horner evaluation of the 7.1.26 polynomial in t, rounded products,
// clamped to [0, 1.0]. Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_hrn (
  input  logic                         clk_i,
  input  logic [ncdf_pkg::HRN_NS-1:0]  en_i,
  input  ncdf_pkg::side_t              side_i,
  output ncdf_pkg::side_t              side_o
);
  import ncdf_pkg::*;

  localparam int STEPS = HRN_NS / 2;
  localparam int LAST  = HRN_NS - 1;

  side_t                  sd_d [HRN_NS];
  side_t                  sd_q [HRN_NS];
  logic signed [HAW-1:0]  acc_q [STEPS];
  logic signed [HAW-1:0]  acc_fin;
  logic [QW-1:0]          pt_c;

  assign acc_fin = acc_q[STEPS-1];

  always_comb begin
    for (int j = 0; j < HRN_NS; j++) begin
      sd_d[j] = (j == 0) ? side_i : sd_q[j-1];
    end
    priority if (acc_fin < 0) begin
      pt_c = '0;
    end else if (acc_fin > $signed(HAW'(QONE))) begin
      pt_c = QONE;
    end else begin
      pt_c = acc_fin[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < HRN_NS; j++) begin
      if (en_i[j]) sd_q[j] <= sd_d[j];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [HAW-1:0] acc_in, mag_s, val;
    logic [32:0]           mag;
    logic [63:0]           mp_q, sum;
    logic                  sn_q;
    logic [33:0]           rnd;

    assign acc_in = (i == 0) ? HRN_A5 : acc_q[(i == 0) ? 0 : i-1];
    assign mag_s  = (acc_in < 0) ? -acc_in : acc_in;
    assign mag    = mag_s[32:0];
    assign sum    = mp_q + 64'h2000_0000;
    assign rnd    = sum[63:30];
    assign val    = sn_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

    always_ff @(posedge clk_i) begin
      if (en_i[2*i]) begin
        mp_q <= mag * sd_d[2*i].t;
        sn_q <= (acc_in < 0);
      end
      if (en_i[2*i+1]) begin
        acc_q[i] <= val + HRN_ADD[i];
      end
    end
  end

  // final accumulator shares the last stage with the side registers
  always_comb begin
    side_o    = sd_q[LAST];
    side_o.pt = pt_c;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ncdf_out.sv -----
// Output stages: erf from the polynomial and exponential, sign, rounding
// to OUT_BITS and saturation. Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_out #(
  parameter int OUT_BITS = ncdf_pkg::OUT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic [ncdf_pkg::OUT_NS-1:0]  en_i,
  input  ncdf_pkg::side_t              side_i,
  output logic [OUT_BITS:0]            probability_o
);
  import ncdf_pkg::*;

  localparam logic [31:0] RND  = 32'(1) << (QB - 1 - OUT_BITS);
  localparam logic [31:0] PMAX = 32'(1) << OUT_BITS;

  logic [61:0]     pe_q;
  logic            below_q, sat_q;
  logic [QW-1:0]   erf;
  logic [31:0]     sum, res;
  logic [OUT_BITS:0] prob_d, prob_q;

  always_comb begin
    erf = sat_q ? QONE : (QONE - pe_q[60:30]);
    sum = below_q ? ({1'b0, QONE} - {1'b0, erf}) : ({1'b0, QONE} + {1'b0, erf});
    res = ({1'b0, sum[31:1]} + RND) >> (QB - OUT_BITS);
    prob_d = (res > PMAX) ? PMAX[OUT_BITS:0] : res[OUT_BITS:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pe_q    <= side_i.pt * side_i.e;
      below_q <= side_i.below;
      sat_q   <= side_i.sat;
    end
    if (en_i[1]) begin
      prob_q <= prob_d;
    end
  end

  assign probability_o = prob_q;

endmodule

`default_nettype wire

// ----- rtl/core/normal_cdf_approximation.sv -----
// Top level of the normal CDF pipeline: config registers, stage valid bits
// and the datapath chain. Depends on ncdf_pkg and the ncdf_* stage modules.
//
//   channel       dir  handshake                              payload
//   sample        in   sample_valid_i / sample_ready_o          sample_i
//   probability   out  probability_valid_o / probability_ready_i  probability_o
//   cfg           in   cfg_we_i (no wait)                       cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the output is not stalled; the pipeline depth is set
// by the one-bit-per-stage divider and the 12-term exponential series.
// Reset clears the valid bits and loads mean = 0, inverse_scale = 46341.
// Each stage holds while full and its successor is stalled; empty stages
// keep filling, so bubbles close up behind a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module normal_cdf_approximation #(
  parameter int FRAC_BITS = ncdf_pkg::FRAC_BITS_DEF,
  parameter int OUT_BITS  = ncdf_pkg::OUT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ncdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [31:0]             sample_i,
  output logic                           probability_valid_o,
  input  logic                           probability_ready_i,
  output logic [OUT_BITS:0]              probability_o
);
  import ncdf_pkg::*;

  localparam int NS = NUM_STAGES;

  logic signed [31:0] mean_q;
  logic [31:0]        inv_scale_q;
  logic [NS-1:0]      v_q, v_d, en;
  logic               adv;
  side_t              s_dist, s_exp, s_div, s_hrn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q      <= '0;
      inv_scale_q <= 32'd46341;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MEAN:      mean_q      <= cfg_wdata_i;
        REG_INV_SCALE: inv_scale_q <= cfg_wdata_i;
      endcase
    end
  end

  assign adv = !v_q[NS-1] || probability_ready_i;

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      en[j] = adv || !v_q[j];
    end
    v_d[0] = en[0] ? sample_valid_i : (v_q[0] && !en[1]);
    for (int j = 1; j < NS - 1; j++) begin
      v_d[j] = en[j] ? v_q[j-1] : (v_q[j] && !en[j+1]);
    end
    v_d[NS-1] = en[NS-1] ? v_q[NS-2] : v_q[NS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign sample_ready_o      = en[0];
  assign probability_valid_o = v_q[NS-1];

  ncdf_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
    .clk_i           (clk_i),
    .en_i            (en[DIST_NS-1:0]),
    .sample_i        (sample_i),
    .mean_i          (mean_q),
    .inverse_scale_i (inv_scale_q),
    .side_o          (s_dist)
  );

  ncdf_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en[EXP_OFS +: EXP_NS]),
    .side_i (s_dist),
    .side_o (s_exp)
  );

  ncdf_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[DIV_OFS +: DIV_NS]),
    .side_i (s_exp),
    .side_o (s_div)
  );

  ncdf_hrn u_hrn (
    .clk_i  (clk_i),
    .en_i   (en[HRN_OFS +: HRN_NS]),
    .side_i (s_div),
    .side_o (s_hrn)
  );

  ncdf_out #(.OUT_BITS(OUT_BITS)) u_out (
    .clk_i         (clk_i),
    .en_i          (en[OUT_OFS +: OUT_NS]),
    .side_i        (s_hrn),
    .probability_o (probability_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ncdf_checker.sv -----
// Port-level checks for normal_cdf_approximation, bound to the top level.
// Depends on ncdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdf_checker #(
  parameter int OUT_BITS = ncdf_pkg::OUT_BITS_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           sample_ready_o,
  input wire logic                           probability_valid_o,
  input wire logic                           probability_ready_i,
  input wire logic [OUT_BITS:0]              probability_o
);

  localparam logic [OUT_BITS:0] PMAX = (OUT_BITS+1)'(1) << OUT_BITS;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probability_valid_o && !probability_ready_i |=>
      probability_valid_o && $stable(probability_o))
    else $error("result item changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probability_valid_o |-> probability_o <= PMAX)
    else $error("probability above 1.0");

  // input side is never blocked unless the output is
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !probability_valid_o || probability_ready_i |-> sample_ready_o)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !probability_valid_o)
    else $error("result item during reset");

endmodule

bind normal_cdf_approximation ncdf_checker #(.OUT_BITS(OUT_BITS)) u_ncdf_checker (.*);

`default_nettype wire

// ----- test/normal_cdf_approximation_tb.sv -----
// Self-checking testbench for normal_cdf_approximation: drives samples with
// random gaps, predicts each probability in fixed point and compares.
// Depends on ncdf_pkg and the normal_cdf_approximation RTL.
`timescale 1ns / 1ps

module normal_cdf_approximation_tb;
  import ncdf_pkg::*;

  localparam int FB = 16;
  localparam int OB = 16;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned HALF30 = 64'd1 << 29;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_MEAN;
  logic [31:0]       cfg_wdata_i = '0;
  logic              sample_valid_i = 1'b0;
  logic              sample_ready_o;
  logic signed [31:0] sample_i = '0;
  logic              probability_valid_o;
  logic              probability_ready_i = 1'b0;
  logic [OB:0]       probability_o;

  logic [31:0] mean_q = 32'd0;
  logic [31:0] iscale_q = 32'd46341;
  logic [OB:0] expected_prob [$];
  int          n_errors = 0;
  bit          ready_free = 1'b0;

  normal_cdf_approximation uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("normal_cdf_approximation_tb NOT OK");
    $finish;
  end

  function automatic longint signed hround(longint signed a, longint unsigned t);
    longint unsigned mag, r;
    mag = (a < 0) ? longint'(-a) : a;
    r = (mag * t + HALF30) >> 30;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned w);
    longint unsigned u, k, f, g, s;
    u = ((w >> 4) * 64'd1549082005) >> 26;
    k = u >> 30;
    f = u & (ONE30 - 1);
    g = (f * 64'd744261118) >> 30;
    s = ONE30;
    for (int n = 12; n >= 1; n--) s = ONE30 - ((g * s) >> 30) / n;
    if (k >= 63) return 0;
    return s >> k;
  endfunction

  function automatic logic [OB:0] cdf_of(logic [31:0] x);
    longint signed diff, acc;
    longint unsigned d, prod, z, t, pt, z28, w, erf, cdf, res;
    bit below;
    diff = longint'($signed(x)) - longint'($signed(mean_q));
    below = diff < 0;
    d = below ? -diff : diff;
    prod = d * longint'({32'd0, iscale_q});
    if (prod >= (64'd6 << 32)) begin
      erf = ONE30;
    end else begin
      z = prod >> 2;
      t = (ONE30 << 30) / (ONE30 + ((64'd351748265 * z) >> 30));
      acc = 1139675401;
      acc = hround(acc, t) - 1560310108;
      acc = hround(acc, t) + 1526231383;
      acc = hround(acc, t) - 305476044;
      acc = hround(acc, t) + 273621191;
      acc = hround(acc, t);
      if (acc < 0) acc = 0;
      pt = acc;
      if (pt > ONE30) pt = ONE30;
      z28 = z >> 2;
      w = (z28 * z28) >> 26;
      erf = ONE30 - ((pt * exp_neg(w)) >> 30);
    end
    cdf = below ? ((ONE30 - erf) >> 1) : ((ONE30 + erf) >> 1);
    res = (cdf + (64'd1 << 13)) >> 14;
    if (res > (64'd1 << OB)) res = 64'd1 << OB;
    return res[OB:0];
  endfunction

  task automatic send_sample(logic [31:0] x);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= x;
    expected_prob.push_back(cdf_of(x));
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  task automatic drain_pipe();
    sample_valid_i <= 1'b0;
    while (expected_prob.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    drain_pipe();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MEAN) mean_q = v; else iscale_q = v;
  endtask

  // receiver stall, redrawn per item
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = ready_free ? 0 : $urandom_range(0, 11);
      if (!ready_free && $urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        probability_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      probability_ready_i <= 1'b1;
      do @(posedge clk_i); while (!probability_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (probability_valid_o && probability_ready_i) begin
      if (expected_prob.size() == 0) begin
        $error("unexpected item: probability %0d", probability_o);
        n_errors++;
      end else begin
        logic [OB:0] e;
        e = expected_prob.pop_front();
        if (probability_o !== e) begin
          $error("probability: expected %0d actual %0d", e, probability_o);
          n_errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(32'h0000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h0001_0000);
    send_sample(32'hffff_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hffff_ffff);
  endtask

  task automatic test_extremes();
    write_reg(REG_MEAN, 32'h7fff_ffff);
    write_reg(REG_INV_SCALE, 32'hffff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h7fff_fffe);
    write_reg(REG_MEAN, 32'h8000_0000);
    write_reg(REG_INV_SCALE, 32'd1);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    write_reg(REG_INV_SCALE, 32'd0);
    send_sample(32'h1234_5678);
    write_reg(REG_MEAN, 32'd0);
    write_reg(REG_INV_SCALE, 32'd46341);
    // near the z = 6 saturation edge
    send_sample(32'h0008_7c00);
    send_sample(32'h0008_7c5f);
    send_sample(32'hfff7_83a0);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 11; ph++) begin
      logic [31:0] m, s;
      m = $urandom();
      if (ph % 3 == 0) m = $signed(m) >>> 12;
      case (ph % 4)
        0: s = $urandom_range(20000, 120000);
        1: s = $urandom_range(1, 4000);
        2: s = $urandom();
        default: s = $urandom_range(120000, 2000000);
      endcase
      write_reg(REG_MEAN, m);
      write_reg(REG_INV_SCALE, s);
      ready_free = (ph == 5);
      for (int i = 0; i < 50; i++) begin
        logic [31:0] x;
        if ($urandom_range(0, 4) == 0) x = $urandom();
        else x = m + ($signed($urandom()) >>> $urandom_range(8, 28));
        send_sample(x);
      end
      ready_free = 1'b0;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_random_settings();
    drain_pipe();
    if (n_errors == 0 && expected_prob.size() == 0)
      $display("normal_cdf_approximation_tb OK");
    else
      $display("normal_cdf_approximation_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ncdf_pkg.sv
rtl/core/ncdf_dist.sv
rtl/core/ncdf_exp.sv
rtl/core/ncdf_div.sv
rtl/core/ncdf_hrn.sv
rtl/core/ncdf_out.sv
rtl/core/normal_cdf_approximation.sv
rtl/core/ncdf_checker.sv
test/normal_cdf_approximation_tb.sv
